// ===== rtl/blp_pkg.sv =====
// bounded positional list: shared types and codes
// request structs, opcode/status/state enums; no dependencies
`default_nettype none

package blp_pkg;

  // fixed field widths of the request and response
  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned LEN_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    status_t                  status;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } out_t;

  // response handed from the sequencer to the output stage
  typedef struct packed {
    logic load;
    out_t data;
  } resp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_DEL_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DMP_RD,
    S_DMP_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/blp_seq.sv =====
// bounded positional list: sequencer, entry memory and shared index unit
// moves one entry at a time through one write and one read port; uses blp_pkg
`default_nettype none

module blp_seq #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire blp_pkg::in_t  in_data,
  input  wire logic          out_free,
  output blp_pkg::resp_t     resp
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CW > blp_pkg::POS_W) ? CW : blp_pkg::POS_W;

  // control and latched request
  blp_pkg::state_t               state_r, state_nxt;
  logic [blp_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [DATA_WIDTH-1:0]         val_r, val_nxt;
  logic [blp_pkg::POS_W-1:0]     slot_r, slot_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [AW-1:0]                 tgt_r, tgt_nxt;
  logic                          dir_up_r, dir_up_nxt;
  blp_pkg::status_t              status_r, status_nxt;
  logic [CW-1:0]                 count_r, count_nxt;

  // entry memory, one write and one registered read port
  logic [DATA_WIDTH-1:0] entries_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  // shared index unit
  logic [CW-1:0]    idx_up;
  logic [AW-1:0]    idx_dn;
  logic [CMP_W-1:0] slot_cmp, count_cmp, tgt_c;
  blp_pkg::opcode_t op_e;

  assign idx_up    = CW'(idx_r) + CW'(1);
  assign idx_dn    = idx_r - AW'(1);
  assign slot_cmp  = CMP_W'(slot_r);
  assign count_cmp = CMP_W'(count_r);
  assign op_e      = blp_pkg::opcode_t'(op_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= entries_mem[mem_raddr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= blp_pkg::S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      tgt_r    <= '0;
      dir_up_r <= 1'b0;
      status_r <= blp_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      tgt_r    <= tgt_nxt;
      dir_up_r <= dir_up_nxt;
      status_r <= status_nxt;
    end
  end

  // latched request payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    slot_r <= slot_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    slot_nxt   = slot_r;
    idx_nxt    = idx_r;
    tgt_nxt    = tgt_r;
    dir_up_nxt = dir_up_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = rdata_r;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    tgt_c      = '0;
    in_ready   = 1'b0;
    resp       = '0;

    case (state_r)
      blp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          val_nxt    = DATA_WIDTH'($unsigned(in_data.value));
          slot_nxt   = (in_data.position <= blp_pkg::POS_W'(1)) ? '0
                       : in_data.position - blp_pkg::POS_W'(1);
          status_nxt = blp_pkg::ST_OK;
          state_nxt  = blp_pkg::S_DECODE;
        end
      end

      blp_pkg::S_DECODE: begin
        case (op_e)
          blp_pkg::OP_INS_FRONT, blp_pkg::OP_INS_BACK, blp_pkg::OP_INS_AT: begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = blp_pkg::ST_FULL;
              state_nxt  = blp_pkg::S_RESP;
            end else if (op_e == blp_pkg::OP_INS_AT && count_r != '0 &&
                         slot_cmp > count_cmp) begin
              status_nxt = blp_pkg::ST_BADPOS;
              state_nxt  = blp_pkg::S_RESP;
            end else begin
              if (op_e == blp_pkg::OP_INS_FRONT || count_r == '0) begin
                tgt_c = '0;
              end else if (op_e == blp_pkg::OP_INS_BACK) begin
                tgt_c = count_cmp;
              end else begin
                tgt_c = slot_cmp;
              end
              tgt_nxt    = AW'(tgt_c);
              idx_nxt    = AW'(count_r);
              dir_up_nxt = 1'b0;
              state_nxt  = blp_pkg::S_INS_CHK;
            end
          end
          blp_pkg::OP_DEL_FRONT, blp_pkg::OP_DEL_BACK, blp_pkg::OP_DEL_AT: begin
            if (count_r == '0) begin
              status_nxt = blp_pkg::ST_EMPTY;
              state_nxt  = blp_pkg::S_RESP;
            end else if (op_e == blp_pkg::OP_DEL_AT && slot_cmp >= count_cmp) begin
              status_nxt = blp_pkg::ST_BADPOS;
              state_nxt  = blp_pkg::S_RESP;
            end else begin
              if (op_e == blp_pkg::OP_DEL_FRONT) begin
                tgt_c = '0;
              end else if (op_e == blp_pkg::OP_DEL_BACK) begin
                tgt_c = count_cmp - CMP_W'(1);
              end else begin
                tgt_c = slot_cmp;
              end
              idx_nxt    = AW'(tgt_c);
              dir_up_nxt = 1'b1;
              state_nxt  = blp_pkg::S_DEL_CHK;
            end
          end
          blp_pkg::OP_DUMP: begin
            if (count_r == '0) begin
              status_nxt = blp_pkg::ST_EMPTY;
              state_nxt  = blp_pkg::S_RESP;
            end else begin
              idx_nxt   = '0;
              state_nxt = blp_pkg::S_DMP_RD;
            end
          end
          default: begin
            state_nxt = blp_pkg::S_RESP;
          end
        endcase
      end

      // insert: move entries up until the hole reaches the target slot
      blp_pkg::S_INS_CHK: begin
        if (idx_r > tgt_r) begin
          state_nxt = blp_pkg::S_SH_RD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = tgt_r;
          mem_wdata = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = blp_pkg::S_RESP;
        end
      end

      // delete: pull later entries down over the removed slot
      blp_pkg::S_DEL_CHK: begin
        if (idx_up < count_r) begin
          state_nxt = blp_pkg::S_SH_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = blp_pkg::S_RESP;
        end
      end

      blp_pkg::S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = dir_up_r ? AW'(idx_up) : idx_dn;
        state_nxt = blp_pkg::S_SH_WR;
      end

      blp_pkg::S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rdata_r;
        idx_nxt   = dir_up_r ? AW'(idx_up) : idx_dn;
        state_nxt = dir_up_r ? blp_pkg::S_DEL_CHK : blp_pkg::S_INS_CHK;
      end

      blp_pkg::S_DMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = blp_pkg::S_DMP_WR;
      end

      // read data holds until the output stage takes it
      blp_pkg::S_DMP_WR: begin
        if (out_free) begin
          resp.load         = 1'b1;
          resp.data.element = blp_pkg::ELEM_W'(rdata_r);
          resp.data.status  = blp_pkg::ST_OK;
          resp.data.last    = (idx_up == count_r);
          resp.data.length  = blp_pkg::LEN_W'(count_r);
          if (idx_up == count_r) begin
            state_nxt = blp_pkg::S_IDLE;
          end else begin
            idx_nxt   = AW'(idx_up);
            state_nxt = blp_pkg::S_DMP_RD;
          end
        end
      end

      blp_pkg::S_RESP: begin
        if (out_free) begin
          resp.load         = 1'b1;
          resp.data.element = '0;
          resp.data.status  = status_r;
          resp.data.last    = 1'b1;
          resp.data.length  = blp_pkg::LEN_W'(count_r);
          state_nxt         = blp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = blp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_positional_list.sv =====
// throughput: one request at a time; each entry move costs a bound check, a read
//   and a write through the one write and one read port of the entry memory
// reset: synchronous active-low rst_n empties the list; entry storage is not cleared
`default_nettype none

module bounded_positional_list #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire blp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output blp_pkg::out_t      out_data
);

  blp_pkg::resp_t resp;
  logic           out_free;
  logic           out_valid_r, out_valid_nxt;
  blp_pkg::out_t  out_r;

  assign out_free = !out_valid_r || out_ready;

  blp_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .resp     (resp)
  );

  // output register
  always_comb begin
    if (resp.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.load) begin
      out_r <= resp.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/blp_checker.sv =====
// bounded positional list: port-level checker and its bind
// watches the top-level ports only; uses blp_pkg
`default_nettype none

module blp_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire blp_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire blp_pkg::out_t out_data
);

  // one request at a time: ready drops right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a request");

  // waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed");

  // every non-ok response ends its request
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != blp_pkg::ST_OK |-> out_data.last)
    else $error("error response not flagged last");

  // element is zero in every non-ok response
  a_err_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != blp_pkg::ST_OK |-> out_data.element == '0)
    else $error("error response carries an element");

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed");

endmodule

bind bounded_positional_list blp_checker u_blp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/bounded_positional_list_tb.sv =====
// testbench for bounded_positional_list: directed and random requests checked per result
// depends on blp_pkg (request/response structs, opcode and status enums) and the rtl top
`default_nettype none

module bounded_positional_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY        = 32;
  localparam int unsigned RANDOM_REQUESTS = 280;
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned LIMIT_CYCLES    = 500000;
  // opcode seven is not decoded as any operation
  localparam logic [blp_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  blp_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  blp_pkg::out_t  out_data;

  // list contents as the block should hold them, and responses still owed
  logic [blp_pkg::VAL_W-1:0] held_values[$];
  blp_pkg::out_t             expected_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned rx_phase    = 0;
  int unsigned rx_mode     = 0;

  bounded_positional_list #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (blp_pkg::VAL_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** bounded_positional_list: FAILED **");
      $finish;
    end
  end

  // apply one accepted request to the list copy and queue its responses
  function automatic void predict_request(input blp_pkg::in_t req);
    blp_pkg::out_t    rsp;
    int unsigned      cnt;
    int unsigned      slot;
    blp_pkg::status_t st;
    cnt  = held_values.size();
    slot = (req.position <= 1) ? 0 : req.position - 1;
    st   = blp_pkg::ST_OK;
    case (req.opcode)
      blp_pkg::OP_INS_FRONT, blp_pkg::OP_INS_BACK, blp_pkg::OP_INS_AT: begin
        if (cnt >= CAPACITY) begin
          st = blp_pkg::ST_FULL;
        end else if (req.opcode == blp_pkg::OP_INS_FRONT || cnt == 0) begin
          held_values.push_front(req.value);
        end else if (req.opcode == blp_pkg::OP_INS_BACK) begin
          held_values.push_back(req.value);
        end else if (slot > cnt) begin
          st = blp_pkg::ST_BADPOS;
        end else begin
          held_values.insert(slot, req.value);
        end
      end
      blp_pkg::OP_DEL_FRONT, blp_pkg::OP_DEL_BACK, blp_pkg::OP_DEL_AT: begin
        if (cnt == 0) begin
          st = blp_pkg::ST_EMPTY;
        end else if (req.opcode == blp_pkg::OP_DEL_FRONT) begin
          void'(held_values.pop_front());
        end else if (req.opcode == blp_pkg::OP_DEL_BACK) begin
          void'(held_values.pop_back());
        end else if (slot >= cnt) begin
          st = blp_pkg::ST_BADPOS;
        end else begin
          held_values.delete(slot);
        end
      end
      blp_pkg::OP_DUMP: begin
        if (cnt != 0) begin
          for (int unsigned i = 0; i < cnt; i++) begin
            rsp.element = held_values[i];
            rsp.status  = blp_pkg::ST_OK;
            rsp.last    = (i + 1 == cnt);
            rsp.length  = cnt[blp_pkg::LEN_W-1:0];
            expected_results.push_back(rsp);
          end
          return;
        end
        st = blp_pkg::ST_EMPTY;
      end
      default: ;
    endcase
    rsp.element = '0;
    rsp.status  = st;
    rsp.last    = 1'b1;
    rsp.length  = blp_pkg::LEN_W'(held_values.size());
    expected_results.push_back(rsp);
  endfunction

  // request monitor and response checker, both on the sampled edge values
  always @(posedge clk) begin : check_results
    blp_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response: element %0d status %0d last %0d length %0d",
                 out_data.element, out_data.status, out_data.last, out_data.length);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.element !== want.element) begin
            $error("element mismatch: expected %0d, got %0d", want.element, out_data.element);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_data.last);
            error_count++;
          end
          if (out_data.length !== want.length) begin
            $error("length mismatch: expected %0d, got %0d", want.length, out_data.length);
            error_count++;
          end
        end
      end
    end
  end

  // response side backpressure: random modes of always ready, random stalls or mostly not ready
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_phase <= $urandom_range(50, 300);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: begin
          if ($urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // drive one request in bursts with random gaps, return once accepted
  task automatic send_request(input logic [blp_pkg::OP_W-1:0] op,
                              input logic [blp_pkg::VAL_W-1:0] val,
                              input logic [blp_pkg::POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_data.opcode   <= op;
    in_data.value    <= val;
    in_data.position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    // let the monitor record the request before the caller reads the list length
    #1;
  endtask

  function automatic logic [blp_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // dump, deletes and the unused opcode on an empty list
  task automatic test_empty_list();
    send_request(blp_pkg::OP_DUMP, '0, '0);
    send_request(blp_pkg::OP_DEL_FRONT, '0, '0);
    send_request(blp_pkg::OP_DEL_BACK, '0, '0);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd5);
    send_request(OP_UNUSED, '1, '1);
  endtask

  // insert into empty ignores position, deleting the only element
  task automatic test_single_element();
    send_request(blp_pkg::OP_INS_AT, 32'h7fff_ffff, 6'd40);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd0);
    send_request(blp_pkg::OP_INS_BACK, 32'h8000_0000, '0);
    send_request(blp_pkg::OP_DUMP, '0, '0);
    send_request(blp_pkg::OP_DEL_BACK, '0, '0);
  endtask

  // front aliases, append at length+1, out-of-range positions
  task automatic test_positions();
    send_request(blp_pkg::OP_INS_FRONT, '1, '0);
    send_request(blp_pkg::OP_INS_AT, '0, 6'd1);
    send_request(blp_pkg::OP_INS_AT, 32'h0000_0005, 6'd3);
    send_request(blp_pkg::OP_INS_AT, 32'h1234_5678, 6'd5);
    send_request(blp_pkg::OP_INS_AT, 32'h1234_5678, 6'd63);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd4);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd3);
    send_request(blp_pkg::OP_DUMP, '0, '0);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd1);
    send_request(blp_pkg::OP_DEL_FRONT, '0, '0);
  endtask

  // fill to capacity, bounce inserts off a full list, dump, then drain
  task automatic test_full_list();
    int unsigned len;
    while (held_values.size() < CAPACITY) begin
      len = held_values.size();
      send_request(blp_pkg::OP_W'($urandom_range(blp_pkg::OP_INS_FRONT, blp_pkg::OP_INS_AT)),
                   random_value(), blp_pkg::POS_W'($urandom_range(0, len + 1)));
    end
    send_request(blp_pkg::OP_INS_FRONT, random_value(), '0);
    send_request(blp_pkg::OP_INS_BACK, random_value(), '0);
    send_request(blp_pkg::OP_INS_AT, random_value(), 6'd63);
    send_request(blp_pkg::OP_DUMP, '0, '0);
    send_request(blp_pkg::OP_DEL_AT, '0, 6'd33);
    while (held_values.size() > 0) begin
      len = held_values.size();
      send_request(blp_pkg::OP_W'($urandom_range(blp_pkg::OP_DEL_FRONT, blp_pkg::OP_DEL_AT)),
                   random_value(), blp_pkg::POS_W'($urandom_range(0, len)));
    end
    send_request(blp_pkg::OP_DUMP, '0, '0);
  endtask

  // random mix with a growth bias that changes every few dozen requests
  task automatic test_random_mix();
    int unsigned grow_pct;
    int unsigned roll;
    int unsigned len;
    logic [blp_pkg::OP_W-1:0]  op;
    logic [blp_pkg::POS_W-1:0] pos;
    grow_pct = 60;
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0)
        grow_pct = $urandom_range(20, 85);
      len  = held_values.size();
      roll = $urandom_range(0, 99);
      if (roll < 6)
        op = blp_pkg::OP_DUMP;
      else if (roll < 8)
        op = OP_UNUSED;
      else if ($urandom_range(0, 99) < grow_pct)
        op = blp_pkg::OP_W'($urandom_range(blp_pkg::OP_INS_FRONT, blp_pkg::OP_INS_AT));
      else
        op = blp_pkg::OP_W'($urandom_range(blp_pkg::OP_DEL_FRONT, blp_pkg::OP_DEL_AT));
      // mostly positions near the list, sometimes anywhere in the field
      if ($urandom_range(0, 7) == 0)
        pos = blp_pkg::POS_W'($urandom_range(0, 63));
      else
        pos = blp_pkg::POS_W'($urandom_range(0, len + 2));
      send_request(op, random_value(), pos);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_single_element();
    test_positions();
    test_full_list();
    test_random_mix();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** bounded_positional_list: PASSED **");
    else
      $display("** bounded_positional_list: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
